// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL modules; clk and rst are taken from the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must never hold outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// cons must hold in the same cycle as ante
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// cons must hold in the cycle after ante
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/lbp_pkg.sv =====
// Shared types, constants and helper functions for the 3x3 LBP stream block.
package lbp_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam logic [QCNT_W-1:0] QFULL = QCNT_W'(QDEPTH);

  localparam logic [11:0] RESET_WIDTH  = 12'd640;
  localparam logic [12:0] RESET_HEIGHT = 13'd480;
  localparam logic [12:0] MAX_HEIGHT   = 13'd4096;

  localparam int unsigned TOP_BIT    = 7;
  localparam logic [3:0]  CENTRE_IDX = 4'd4;
  // window positions of the neighbours, top-left first, going clockwise
  localparam logic [3:0] NB_ORDER [8] = '{4'd0, 4'd1, 4'd2, 4'd5, 4'd8, 4'd7, 4'd6, 4'd3};

  typedef enum logic [1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1
  } cfg_index_t;

  typedef struct packed {
    logic [8:0][7:0] win;
    logic [11:0]     row;
    logic [10:0]     col;
    logic            last;
  } item_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              empty;
  } q_stat_t;

  // last column index of a row, width clamped to 3..cap
  function automatic logic [10:0] last_col_of(input logic [11:0] w, input logic [11:0] cap);
    logic [11:0] e;
    e = w;
    if (e < 12'd3) e = 12'd3;
    if (e > cap) e = cap;
    return 11'(e - 12'd1);
  endfunction

  // last row index of a frame, height clamped to 3..4096
  function automatic logic [11:0] last_row_of(input logic [12:0] h);
    logic [12:0] e;
    e = h;
    if (e < 13'd3) e = 13'd3;
    if (e > MAX_HEIGHT) e = MAX_HEIGHT;
    return 12'(e - 13'd1);
  endfunction

endpackage

// ===== hdl/lbp_front.sv =====
// Front end: position tracking, line store, 3x3 window and classification of interior pixels.
`include "assert_macros.svh"

module lbp_front #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           pixel,
  input  logic                 push,
  output logic                 full,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [12:0]          cfg_data,
  input  lbp_pkg::q_stat_t     q_stat,
  output logic                 q_push,
  output lbp_pkg::item_t       q_item
);

  localparam int LINE_DEPTH = (MAX_WIDTH < 2048) ? MAX_WIDTH : 2048;
  localparam int AW = $clog2(LINE_DEPTH);
  localparam logic [11:0] CAP = 12'(LINE_DEPTH);

  // one word per column: [15:8] two rows up, [7:0] one row up
  logic [15:0] line_mem [LINE_DEPTH];
  logic [15:0] rdata;

  logic [10:0] c;
  logic [11:0] r;
  logic [10:0] last_col;
  logic [11:0] last_row;

  logic        accept;
  logic        s2_valid;
  logic [7:0]  s2_px;
  logic [10:0] s2_c;
  logic [11:0] s2_r;
  logic        s2_interior;
  logic        s2_last;

  logic [8:0][7:0] win;
  logic [8:0][7:0] win_next;

  // room must cover the item still in the read stage
  assign full   = (q_stat.count + {{(lbp_pkg::QCNT_W-1){1'b0}}, s2_valid}) >= lbp_pkg::QFULL;
  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (accept) begin
      rdata <= line_mem[AW'(c)];
    end
    if (s2_valid) begin
      line_mem[AW'(s2_c)] <= {rdata[7:0], s2_px};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c        <= '0;
      r        <= '0;
      last_col <= lbp_pkg::last_col_of(lbp_pkg::RESET_WIDTH, CAP);
      last_row <= lbp_pkg::last_row_of(lbp_pkg::RESET_HEIGHT);
      s2_valid <= 1'b0;
      win      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          lbp_pkg::CFG_IMAGE_WIDTH: begin
            last_col <= lbp_pkg::last_col_of(cfg_data[11:0], CAP);
            c        <= '0;
            r        <= '0;
          end
          lbp_pkg::CFG_IMAGE_HEIGHT: begin
            last_row <= lbp_pkg::last_row_of(cfg_data);
            c        <= '0;
            r        <= '0;
          end
          default: ;
        endcase
      end else if (accept) begin
        if (c == last_col) begin
          c <= '0;
          r <= (r == last_row) ? '0 : r + 12'd1;
        end else begin
          c <= c + 11'd1;
        end
      end
      s2_valid <= accept;
      if (s2_valid) begin
        win <= win_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s2_px       <= pixel;
      s2_c        <= c;
      s2_r        <= r;
      s2_interior <= (r >= 12'd2) && (c >= 11'd2);
      s2_last     <= (r == last_row) && (c == last_col);
    end
  end

  always_comb begin
    win_next    = win;
    win_next[0] = win[1];
    win_next[1] = win[2];
    win_next[2] = rdata[15:8];
    win_next[3] = win[4];
    win_next[4] = win[5];
    win_next[5] = rdata[7:0];
    win_next[6] = win[7];
    win_next[7] = win[8];
    win_next[8] = s2_px;
  end

  assign q_push      = s2_valid && s2_interior;
  assign q_item.win  = win_next;
  assign q_item.row  = s2_r - 12'd1;
  assign q_item.col  = s2_c - 11'd1;
  assign q_item.last = s2_last;

  `ASSERT_NEXT(a_fr_col_step, accept && !cfg_we && c != last_col, c == $past(c) + 11'd1, "column did not advance")
  `ASSERT_NEXT(a_fr_col_wrap, accept && !cfg_we && c == last_col, c == 11'd0, "column did not wrap at row end")
  `ASSERT_NEVER(a_fr_room, q_push && q_stat.count == lbp_pkg::QFULL, "item pushed into a full queue")

endmodule

// ===== hdl/lbp_queue.sv =====
// Short queue of classified window items between the front and back ends.
`include "assert_macros.svh"

module lbp_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  lbp_pkg::item_t   item,
  input  logic             pop,
  output lbp_pkg::item_t   head,
  output lbp_pkg::q_stat_t stat
);

  localparam logic [lbp_pkg::QPTR_W-1:0] PTR_ONE = {{(lbp_pkg::QPTR_W-1){1'b0}}, 1'b1};
  localparam logic [lbp_pkg::QCNT_W-1:0] CNT_ONE = {{(lbp_pkg::QCNT_W-1){1'b0}}, 1'b1};

  lbp_pkg::item_t entries [lbp_pkg::QDEPTH];

  logic [lbp_pkg::QPTR_W-1:0] wr_ptr;
  logic [lbp_pkg::QPTR_W-1:0] rd_ptr;
  logic [lbp_pkg::QCNT_W-1:0] q_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PTR_ONE;
      if (pop)  rd_ptr <= rd_ptr + PTR_ONE;
      case ({push, pop})
        2'b10:   q_count <= q_count + CNT_ONE;
        2'b01:   q_count <= q_count - CNT_ONE;
        default: q_count <= q_count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= item;
    end
  end

  assign head       = entries[rd_ptr];
  assign stat.count = q_count;
  assign stat.empty = (q_count == '0);

  `ASSERT_NEVER(a_q_overflow, push && !pop && q_count == lbp_pkg::QFULL, "queue overflow")
  `ASSERT_NEVER(a_q_underflow, pop && q_count == '0, "queue underflow")
  `ASSERT_IMPLIES(a_q_ptrs, q_count == '0, wr_ptr == rd_ptr, "pointers apart on an empty queue")

endmodule

// ===== hdl/lbp_back.sv =====
// Back end: eight neighbour compares and the result register.
module lbp_back (
  input  logic                  clk,
  input  logic                  rst,
  input  lbp_pkg::item_t        head,
  input  lbp_pkg::q_stat_t      q_stat,
  output logic                  q_pop,
  output logic [7:0]            code,
  output logic [11:0]           centre_row,
  output logic [10:0]           centre_col,
  output logic                  frame_last,
  output logic                  empty,
  input  logic                  pop
);

  logic       out_valid;
  logic       take;
  logic [7:0] code_next;

  // neighbour >= centre gives a set bit, top-left in the top bit
  always_comb begin
    code_next = '0;
    for (int k = 0; k < 8; k++) begin
      code_next[3'(lbp_pkg::TOP_BIT - k)] =
        head.win[lbp_pkg::NB_ORDER[k]] >= head.win[lbp_pkg::CENTRE_IDX];
    end
  end

  assign take  = !out_valid || pop;
  assign q_pop = !q_stat.empty && take;
  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      code       <= code_next;
      centre_row <= head.row;
      centre_col <= head.col;
      frame_last <= head.last;
    end
  end

endmodule

// ===== hdl/lbp_3x3_image_stream.sv =====
// Top level of the streaming 3x3 local binary pattern block.
//
// Pixels of a grayscale frame enter in raster order through push/full; a
// pixel is taken at a clock edge with push high and full low. Each interior
// pixel's 8-bit pattern (top-left neighbour in bit 7, clockwise, left in
// bit 0) leaves through empty/pop with its centre row and column; frame_last
// marks the last interior code of a frame. Border pixels give no result.
// The configuration channel (cfg_valid/cfg_ready, always ready) sets image
// width (index 0) and height (index 1); either write restarts the frame.
// Write it only while no results are pending.
// One pixel per clock is sustained while full stays low. Each result
// passes from the registered line-store read through the item queue
// into the result register. When pop is held low, results build up in
// a four-entry queue and full rises once it cannot take the item still
// in the line-store stage.
// Synchronous reset sets the width to 640, height to 480 and position to
// the frame start; line-store contents are undefined until written.
module lbp_3x3_image_stream #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  pixel,
  input  logic        push,
  output logic        full,
  output logic [7:0]  code,
  output logic [11:0] centre_row,
  output logic [10:0] centre_col,
  output logic        frame_last,
  output logic        empty,
  input  logic        pop,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  lbp_pkg::item_t   q_item;
  lbp_pkg::item_t   q_head;
  lbp_pkg::q_stat_t q_stat;
  logic             q_push;
  logic             q_pop;

  assign cfg_ready = 1'b1;

  lbp_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .pixel     (pixel),
    .push      (push),
    .full      (full),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_item    (q_item)
  );

  lbp_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .item (q_item),
    .pop  (q_pop),
    .head (q_head),
    .stat (q_stat)
  );

  lbp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .q_stat     (q_stat),
    .q_pop      (q_pop),
    .code       (code),
    .centre_row (centre_row),
    .centre_col (centre_col),
    .frame_last (frame_last),
    .empty      (empty),
    .pop        (pop)
  );

endmodule
